// ===== hw/rtl/dmx512_slot_receiver_macros.svh =====
// ----------------------------------------------------------------------------
// DMX512 slot receiver assertion macros
// Clocked, reset-qualified property shorthands used by the receiver core.
// ----------------------------------------------------------------------------
`ifndef DMX512_SLOT_RECEIVER_MACROS_SVH
`define DMX512_SLOT_RECEIVER_MACROS_SVH

// same-cycle implication
`define DMX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dmx512 slot receiver: implication check failed");

// next-cycle implication
`define DMX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dmx512 slot receiver: next-cycle check failed");

`endif

// ===== hw/rtl/dmx_rx_pkg.sv =====
// ----------------------------------------------------------------------------
// DMX512 slot receiver package
// Shared types, register indexes, reset values and start codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dmx_rx_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int START_SLOT_MAX = 511;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 16;
    localparam int SLOT_W     = 9;
    localparam int CNT_W      = 10;
    localparam int BYTE_W     = 8;

    localparam logic [TIME_W-1:0] BREAK_MIN_RST  = 16'd80;
    localparam logic [TIME_W-1:0] BREAK_MAX_RST  = 16'd10000;
    localparam logic [TIME_W-1:0] MARK_MIN_RST   = 16'd8;
    localparam logic [SLOT_W-1:0] START_SLOT_RST = 9'd0;

    localparam logic [BYTE_W-1:0] START_CODE_DATA = 8'h00;
    localparam logic [BYTE_W-1:0] START_CODE_TEST = 8'h17;

    localparam logic MODE_TIMER = 1'b0;
    localparam logic MODE_BYTE  = 1'b1;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_TEST = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BREAK_MIN  = 2'd0,
        CFG_BREAK_MAX  = 2'd1,
        CFG_MARK_MIN   = 2'd2,
        CFG_START_SLOT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              framing_error;
        logic [BYTE_W-1:0] rx_data;
        logic [TIME_W-1:0] mark_end_capture;
        logic [TIME_W-1:0] break_capture;
        logic              mode;
    } t_in_item;

    typedef struct packed {
        logic              capture_armed;
        logic              start_code_error;
        logic              packet_kind;
        logic              frame_started;
        logic [BYTE_W-1:0] slot_value;
        logic [SLOT_W-1:0] slot_index;
        logic              slot_write;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hw/rtl/dmx_rx_in_reg.sv =====
// ----------------------------------------------------------------------------
// DMX512 input register
// Holds one accepted input transfer until the core stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dmx_rx_in_reg
    import dmx_rx_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_in_item      o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dmx_rx_core.sv =====
// ----------------------------------------------------------------------------
// DMX512 receiver core
// Break qualification, start code decode, slot window and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dmx512_slot_receiver_macros.svh"

module dmx_rx_core
    import dmx_rx_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_in_item              i_item,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_out_item                  o_item
);

    localparam int LIMIT_W = $clog2(START_SLOT_MAX + SLOT_COUNT + 1);
    localparam logic [LIMIT_W-1:0] SLOT_COUNT_L = LIMIT_W'(SLOT_COUNT);

    logic [TIME_W-1:0] r_break_min;
    logic [TIME_W-1:0] r_break_max;
    logic [TIME_W-1:0] r_mark_min;
    logic [SLOT_W-1:0] r_start_slot;

    logic              r_reading;
    logic              r_break_seen;
    logic              r_armed;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_error;
    logic              r_kind;

    logic              n_reading;
    logic              n_break_seen;
    logic              n_armed;
    logic [CNT_W-1:0]  n_cnt;
    logic              n_error;
    logic              n_kind;

    logic              r_out_valid;
    logic              n_out_valid;
    t_out_item         r_out;
    t_out_item         n_out;

    logic              load;
    logic [TIME_W-1:0] mab;
    logic [CNT_W-1:0]  start_ext;
    logic [CNT_W-1:0]  cnt_inc;
    logic [LIMIT_W-1:0] limit;

    assign o_ready   = !r_out_valid || i_ready;
    assign load      = i_valid && o_ready;
    assign o_valid   = r_out_valid;
    assign o_item    = r_out;

    assign mab       = i_item.mark_end_capture - i_item.break_capture;
    assign start_ext = CNT_W'(r_start_slot);
    assign cnt_inc   = r_cnt + CNT_W'(1);
    assign limit     = LIMIT_W'(r_start_slot) + SLOT_COUNT_L;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break_min  <= BREAK_MIN_RST;
            r_break_max  <= BREAK_MAX_RST;
            r_mark_min   <= MARK_MIN_RST;
            r_start_slot <= START_SLOT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_BREAK_MIN:  r_break_min  <= i_cfg_data;
                CFG_BREAK_MAX:  r_break_max  <= i_cfg_data;
                CFG_MARK_MIN:   r_mark_min   <= i_cfg_data;
                CFG_START_SLOT: r_start_slot <= i_cfg_data[SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_reading    = r_reading;
        n_break_seen = r_break_seen;
        n_armed      = r_armed;
        n_cnt        = r_cnt;
        n_error      = r_error;
        n_kind       = r_kind;
        n_out        = '0;

        if (i_item.mode == MODE_TIMER) begin
            if (r_armed && (i_item.break_capture > r_break_min)
                    && (i_item.break_capture < r_break_max) && (mab > r_mark_min)) begin
                n_break_seen = 1'b1;
                n_armed      = 1'b0;
            end
        end else if (i_item.framing_error) begin
            n_armed = 1'b1;
        end else if (r_reading) begin
            if (r_cnt >= start_ext) begin
                n_out.slot_write = 1'b1;
                n_out.slot_index = SLOT_W'(r_cnt - start_ext);
                n_out.slot_value = i_item.rx_data;
            end
            n_cnt = cnt_inc;
            if (LIMIT_W'(cnt_inc) >= limit) begin
                n_reading = 1'b0;
            end
        end else if (r_break_seen) begin
            n_error             = 1'b0;
            n_cnt               = '0;
            n_break_seen        = 1'b0;
            n_out.frame_started = 1'b1;
            if (i_item.rx_data == START_CODE_DATA) begin
                n_kind    = KIND_DATA;
                n_reading = 1'b1;
            end else if (i_item.rx_data == START_CODE_TEST) begin
                n_kind    = KIND_TEST;
                n_reading = 1'b1;
            end else begin
                n_error = 1'b1;
                n_armed = 1'b1;
            end
        end

        n_out.packet_kind      = n_kind;
        n_out.start_code_error = n_error;
        n_out.capture_armed    = n_armed;

        n_out_valid = r_out_valid;
        if (o_ready) begin
            n_out_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reading    <= 1'b0;
            r_break_seen <= 1'b0;
            r_armed      <= 1'b1;
            r_cnt        <= '0;
            r_error      <= 1'b1;
            r_kind       <= KIND_DATA;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (load) begin
                r_reading    <= n_reading;
                r_break_seen <= n_break_seen;
                r_armed      <= n_armed;
                r_cnt        <= n_cnt;
                r_error      <= n_error;
                r_kind       <= n_kind;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    `DMX_ASSERT_IMP(a_write_no_error, i_clk, i_rst_n, r_out_valid && r_out.slot_write, !r_out.start_code_error)
    `DMX_ASSERT_IMP(a_start_no_write, i_clk, i_rst_n, r_out_valid && r_out.frame_started, !r_out.slot_write)
    `DMX_ASSERT_IMP(a_good_start_reads, i_clk, i_rst_n, r_out_valid && r_out.frame_started && !r_out.start_code_error, r_reading && !r_break_seen)
    `DMX_ASSERT_NXT(a_state_holds_idle, i_clk, i_rst_n, !load && !i_cfg_we, $stable(r_cnt) && $stable(r_armed))

endmodule

`default_nettype wire

// ===== hw/rtl/dmx512_slot_receiver.sv =====
// ----------------------------------------------------------------------------
// DMX512 slot receiver
// Qualifies break timing, decodes the start code and emits slot writes.
// ----------------------------------------------------------------------------
// Accepts one transfer per clock while not stalled and returns exactly one result
// transfer for each: the input register holds the transfer, then the receiver
// state is updated and the result is written into the result register. Each
// stage stalls only while it holds a transfer the next stage cannot take. Timer
// captures and received bytes share the input stream, selected by tuser;
// configuration writes take effect at once and belong in idle periods.
`default_nettype none

module dmx512_slot_receiver
    import dmx_rx_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // break_capture[15:0], mark_end_capture[31:16], rx_data[39:32]
    input  wire logic [39:0]           s_axis_tdata,
    // mode[0], framing_error[1]
    input  wire logic [1:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // slot_write[0], slot_index[9:1], slot_value[17:10], frame_started[18],
    // start_code_error[19], capture_armed[20], zero[23:21]
    output logic [23:0]                m_axis_tdata,
    // packet_kind[0]
    output logic                       m_axis_tuser
);

    t_in_item  in_item;
    t_in_item  reg_item;
    t_out_item out_item;
    logic      reg_valid;
    logic      core_ready;

    assign in_item.mode             = s_axis_tuser[0];
    assign in_item.framing_error    = s_axis_tuser[1];
    assign in_item.break_capture    = s_axis_tdata[15:0];
    assign in_item.mark_end_capture = s_axis_tdata[31:16];
    assign in_item.rx_data          = s_axis_tdata[39:32];

    dmx_rx_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (reg_valid),
        .i_ready (core_ready),
        .o_item  (reg_item)
    );

    dmx_rx_core #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_valid    (reg_valid),
        .o_ready    (core_ready),
        .i_item     (reg_item),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_item     (out_item)
    );

    assign m_axis_tdata = {3'b000,
                           out_item.capture_armed,
                           out_item.start_code_error,
                           out_item.frame_started,
                           out_item.slot_value,
                           out_item.slot_index,
                           out_item.slot_write};
    assign m_axis_tuser = out_item.packet_kind;

endmodule

`default_nettype wire

// ===== dv/tb_dmx512_slot_receiver.sv =====
// ----------------------------------------------------------------------------
// DMX512 slot receiver testbench
// Streams timer captures and received bytes into the receiver. A transfer-level
// shadow of the receiver state predicts each result transfer, and the
// results are checked field by field in order. The limits and the window
// start are varied between phases, both sides idle at random, and one long
// output hold-off backs the pipe up into the input.
// ----------------------------------------------------------------------------
module tb_dmx512_slot_receiver;
    import dmx_rx_pkg::*;

    localparam int SLOTS        = SLOT_COUNT_DEF;
    localparam int PIPE_DRAIN   = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int WDOG_LIMIT   = 4000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;
    logic                  m_axis_tuser;

    // shadow configuration and receiver state
    logic [TIME_W-1:0] brk_min_q, brk_max_q, mark_min_q;
    logic [SLOT_W-1:0] win_start_q;
    logic              in_slots, brk_noted, cap_armed, err_flag, kind_q;
    logic [CNT_W-1:0]  slot_cnt;

    t_out_item awaited_results[$];
    int        err_cnt     = 0;
    int        n_sent      = 0;
    int        idle_cycles = 0;
    int        burst_left  = 0;
    bit        gaps_on     = 1'b1;
    bit        hold_req    = 1'b0;

    dmx512_slot_receiver #(
        .SLOT_COUNT(SLOTS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic reset_shadow();
        brk_min_q   = BREAK_MIN_RST;
        brk_max_q   = BREAK_MAX_RST;
        mark_min_q  = MARK_MIN_RST;
        win_start_q = START_SLOT_RST;
        in_slots    = 1'b0;
        brk_noted   = 1'b0;
        cap_armed   = 1'b1;
        slot_cnt    = '0;
        err_flag    = 1'b1;
        kind_q      = KIND_DATA;
    endtask

    task automatic rx_state_step(input t_in_item it, output t_out_item res);
        logic [TIME_W-1:0] mab;
        int                win_end;
        res     = '0;
        mab     = it.mark_end_capture - it.break_capture;
        win_end = int'(win_start_q) + SLOTS;
        if (it.mode == MODE_TIMER) begin
            if (cap_armed && it.break_capture > brk_min_q && it.break_capture < brk_max_q
                    && mab > mark_min_q) begin
                brk_noted = 1'b1;
                cap_armed = 1'b0;
            end
        end else if (it.framing_error) begin
            cap_armed = 1'b1;
        end else if (in_slots) begin
            if (slot_cnt >= CNT_W'(win_start_q)) begin
                res.slot_write = 1'b1;
                res.slot_index = SLOT_W'(slot_cnt - CNT_W'(win_start_q));
                res.slot_value = it.rx_data;
            end
            slot_cnt = slot_cnt + CNT_W'(1);
            if (int'(slot_cnt) >= win_end)
                in_slots = 1'b0;
        end else if (brk_noted) begin
            err_flag          = 1'b0;
            slot_cnt          = '0;
            brk_noted         = 1'b0;
            res.frame_started = 1'b1;
            if (it.rx_data == START_CODE_DATA) begin
                kind_q   = KIND_DATA;
                in_slots = 1'b1;
            end else if (it.rx_data == START_CODE_TEST) begin
                kind_q   = KIND_TEST;
                in_slots = 1'b1;
            end else begin
                err_flag  = 1'b1;
                cap_armed = 1'b1;
            end
        end
        res.packet_kind      = kind_q;
        res.start_code_error = err_flag;
        res.capture_armed    = cap_armed;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_in_item  seen;
        t_out_item want;
        t_out_item got;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_BREAK_MIN:  brk_min_q   = i_cfg_data;
                    CFG_BREAK_MAX:  brk_max_q   = i_cfg_data;
                    CFG_MARK_MIN:   mark_min_q  = i_cfg_data;
                    CFG_START_SLOT: win_start_q = i_cfg_data[SLOT_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen.break_capture    = s_axis_tdata[15:0];
                seen.mark_end_capture = s_axis_tdata[31:16];
                seen.rx_data          = s_axis_tdata[39:32];
                seen.mode             = s_axis_tuser[0];
                seen.framing_error    = s_axis_tuser[1];
                rx_state_step(seen, want);
                awaited_results.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with no input transfer pending");
                    err_cnt++;
                end else begin
                    want = awaited_results.pop_front();
                    got.slot_write       = m_axis_tdata[0];
                    got.slot_index       = m_axis_tdata[9:1];
                    got.slot_value       = m_axis_tdata[17:10];
                    got.frame_started    = m_axis_tdata[18];
                    got.start_code_error = m_axis_tdata[19];
                    got.capture_armed    = m_axis_tdata[20];
                    got.packet_kind      = m_axis_tuser;
                    check_field("slot_write", 32'(want.slot_write), 32'(got.slot_write));
                    check_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
                    check_field("slot_value", 32'(want.slot_value), 32'(got.slot_value));
                    check_field("frame_started", 32'(want.frame_started),
                                32'(got.frame_started));
                    check_field("packet_kind", 32'(want.packet_kind), 32'(got.packet_kind));
                    check_field("start_code_error", 32'(want.start_code_error),
                                32'(got.start_code_error));
                    check_field("capture_armed", 32'(want.capture_armed),
                                32'(got.capture_armed));
                    check_field("tdata_pad", 32'd0, 32'(m_axis_tdata[23:21]));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : result_sink
        int style;
        int left;
        int hold;
        m_axis_tready = 1'b0;
        style = 0;
        left  = 0;
        hold  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold     = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (left == 0) begin
                style = $urandom_range(0, 3);
                left  = $urandom_range(20, 150);
            end
            left--;
            if (hold > 0) begin
                hold--;
                m_axis_tready = 1'b0;
            end else begin
                case (style)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = ($urandom % 4) != 0;
                    2: m_axis_tready = (left % 7) < 5;
                    default: m_axis_tready = 1'($urandom % 2);
                endcase
            end
        end
    end

    function automatic t_in_item timer_item(input logic [TIME_W-1:0] brk,
                                            input logic [TIME_W-1:0] mend);
        t_in_item it;
        it.mode             = MODE_TIMER;
        it.break_capture    = brk;
        it.mark_end_capture = mend;
        it.rx_data          = BYTE_W'($urandom);
        it.framing_error    = 1'($urandom);
        return it;
    endfunction

    function automatic t_in_item byte_item(input logic [BYTE_W-1:0] data, input logic fe);
        t_in_item it;
        it.mode             = MODE_BYTE;
        it.break_capture    = TIME_W'($urandom);
        it.mark_end_capture = TIME_W'($urandom);
        it.rx_data          = data;
        it.framing_error    = fe;
        return it;
    endfunction

    function automatic t_in_item noise_item();
        t_in_item it;
        it.mode             = 1'($urandom);
        it.break_capture    = TIME_W'($urandom);
        it.mark_end_capture = TIME_W'($urandom);
        it.rx_data          = BYTE_W'($urandom);
        it.framing_error    = 1'($urandom);
        return it;
    endfunction

    function automatic t_in_item good_break();
        logic [TIME_W-1:0] brk;
        logic [TIME_W-1:0] mab;
        brk = TIME_W'($urandom);
        mab = TIME_W'($urandom);
        if (int'(brk_max_q) > int'(brk_min_q) + 1) begin
            case ($urandom % 4)
                0: brk = brk_min_q + TIME_W'(1);
                1: brk = brk_max_q - TIME_W'(1);
                default: brk = TIME_W'($urandom_range(int'(brk_min_q) + 1,
                                                      int'(brk_max_q) - 1));
            endcase
        end
        if (mark_min_q != 16'hFFFF)
            mab = ($urandom % 4 == 0) ? mark_min_q + TIME_W'(1)
                                      : TIME_W'($urandom_range(int'(mark_min_q) + 1, 65535));
        return timer_item(brk, brk + mab);
    endfunction

    function automatic t_in_item bad_break();
        logic [TIME_W-1:0] brk;
        case ($urandom % 4)
            0: return timer_item(brk_min_q, brk_min_q + mark_min_q + TIME_W'(1));
            1: return timer_item(brk_max_q, brk_max_q + mark_min_q + TIME_W'(1));
            2: begin
                brk = brk_min_q + TIME_W'(1);
                return timer_item(brk, brk + mark_min_q);
            end
            default: return timer_item(TIME_W'($urandom), TIME_W'($urandom));
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {it.rx_data, it.mark_end_capture, it.break_capture};
        s_axis_tuser  = {it.framing_error, it.mode};
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0)
            burst_left--;
        n_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic set_limits(input logic [TIME_W-1:0] bmin, input logic [TIME_W-1:0] bmax,
                              input logic [TIME_W-1:0] mmin, input logic [SLOT_W-1:0] first);
        wait_idle();
        cfg_write(CFG_BREAK_MIN, bmin);
        cfg_write(CFG_BREAK_MAX, bmax);
        cfg_write(CFG_MARK_MIN, mmin);
        cfg_write(CFG_START_SLOT, CFG_DATA_W'(first));
    endtask

    task automatic send_frame();
        int n_slots;
        int r;
        logic [BYTE_W-1:0] code;
        if ($urandom % 5 != 0)
            send_item(byte_item(BYTE_W'($urandom), 1'b1));
        if ($urandom % 8 == 0)
            send_item(bad_break());
        send_item(($urandom % 10 != 0) ? good_break() : bad_break());
        if ($urandom % 10 == 0)
            send_item(good_break());
        r = $urandom % 20;
        code = (r < 9) ? START_CODE_DATA : (r < 16) ? START_CODE_TEST : BYTE_W'($urandom);
        send_item(byte_item(code, 1'b0));
        if ($urandom % 4 != 0)
            n_slots = int'(win_start_q) + SLOTS + $urandom_range(0, 2);
        else
            n_slots = $urandom_range(0, int'(win_start_q) + SLOTS + 2);
        for (int i = 0; i < n_slots; i++) begin
            r = $urandom % 30;
            if (r == 0)
                send_item(byte_item(BYTE_W'($urandom), 1'b1));
            else if (r == 1)
                send_item(good_break());
            else
                send_item(byte_item(BYTE_W'($urandom), 1'b0));
        end
        if ($urandom % 6 == 0)
            repeat ($urandom_range(1, 3)) send_item(noise_item());
    endtask

    task automatic run_frames(input int n);
        int target;
        target = n_sent + n;
        while (n_sent < target)
            send_frame();
    endtask

    task automatic test_break_timing();
        send_item(byte_item(START_CODE_DATA, 1'b0));
        send_item(timer_item(16'd80, 16'd200));
        send_item(timer_item(16'd10000, 16'd10100));
        send_item(timer_item(16'd100, 16'd108));
        send_item(timer_item(16'h0000, 16'h0000));
        send_item(timer_item(16'hFFFF, 16'hFFFF));
        // mark length wraps modulo 2^16
        send_item(timer_item(16'd100, 16'd50));
        send_item(timer_item(16'd500, 16'd600));
        send_item(byte_item(8'hFF, 1'b1));
    endtask

    task automatic test_start_codes();
        send_item(byte_item(START_CODE_TEST, 1'b0));
        send_item(byte_item(8'h00, 1'b0));
        send_item(byte_item(8'hFF, 1'b0));
        send_item(byte_item(8'hA5, 1'b1));
        send_item(timer_item(16'd81, 16'd90));
        repeat (SLOTS - 2) send_item(byte_item(BYTE_W'($urandom), 1'b0));
        send_item(byte_item(8'h42, 1'b0));
        send_item(timer_item(16'd9999, 16'd10008));
        send_item(byte_item(START_CODE_DATA, 1'b0));
        send_item(byte_item(8'hFF, 1'b0));
        send_item(byte_item(8'h00, 1'b0));
    endtask

    task automatic test_default_frames();
        run_frames(50);
    endtask

    task automatic test_backpressure();
        wait_idle();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        run_frames(40);
        gaps_on  = 1'b1;
    endtask

    task automatic test_wide_limits();
        set_limits(16'h0000, 16'hFFFF, 16'h0000, 9'd0);
        run_frames(30);
    endtask

    task automatic test_closed_limits();
        set_limits(16'hFFFF, 16'h0000, 16'hFFFF, 9'd1);
        run_frames(20);
    endtask

    task automatic test_random_limits();
        int bmin;
        int bmax;
        for (int k = 0; k < 3; k++) begin
            bmin = $urandom_range(0, 2000);
            bmax = bmin + $urandom_range(2, 20000);
            set_limits(TIME_W'(bmin), TIME_W'(bmax), TIME_W'($urandom_range(0, 500)),
                       SLOT_W'($urandom_range(0, 6)));
            run_frames(10);
        end
    endtask

    task automatic test_far_window();
        set_limits(BREAK_MIN_RST, BREAK_MAX_RST, MARK_MIN_RST, SLOT_W'(START_SLOT_MAX));
        send_item(byte_item(8'h3C, 1'b1));
        send_item(good_break());
        send_item(byte_item(START_CODE_DATA, 1'b0));
        repeat (START_SLOT_MAX + SLOTS + 2)
            send_item(byte_item(BYTE_W'($urandom), 1'b0));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        reset_shadow();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_break_timing();
        test_start_codes();
        test_default_frames();
        test_backpressure();
        test_wide_limits();
        test_closed_limits();
        test_random_limits();
        test_far_window();

        wait_idle();
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== dmx512_slot_receiver.f =====
+incdir+hw/rtl
hw/rtl/dmx_rx_pkg.sv
hw/rtl/dmx_rx_in_reg.sv
hw/rtl/dmx_rx_core.sv
hw/rtl/dmx512_slot_receiver.sv
dv/tb_dmx512_slot_receiver.sv
